/* rtl/core/brf_pkg.sv */
// ---------------------------------------------------------------------------
// Byte ring FIFO package
// Shared sizes, opcodes and the capacity clamp for the byte ring FIFO core.
// ---------------------------------------------------------------------------
package brf_pkg;

   localparam int DEPTH       = 4096;
   localparam int MAX_REQUEST = 64;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = ADDR_W + 1;
   localparam int LEN_W  = 7;
   localparam int FILL_W = 13;
   localparam int BYTE_W = 8;
   localparam int OP_W   = 3;
   localparam int LG_W   = 4;
   localparam int CMP_W  = (PTR_W > LEN_W) ? PTR_W : LEN_W;
   localparam int LG_MAX = (ADDR_W < 12) ? ADDR_W : 12;
   localparam int LG_RESET = 12;

   typedef enum logic [OP_W-1:0] {
      OP_PUT_PARTIAL = 3'd0,
      OP_PUT_FIXED   = 3'd1,
      OP_GET_PARTIAL = 3'd2,
      OP_GET_FIXED   = 3'd3,
      OP_CLEAR       = 3'd4
   } opcode_type;

   function automatic logic [LG_W-1:0] cap_lg_clamp(input logic [LG_W-1:0] value);
      logic [LG_W-1:0] result;
      result = value;
      if (value < LG_W'(1)) begin
         result = LG_W'(1);
      end
      if (value > LG_W'(LG_MAX)) begin
         result = LG_W'(LG_MAX);
      end
      return result;
   endfunction

endpackage

/* rtl/core/brf_ram.sv */
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/byte_ring_fifo_bulk_core.sv */
// ---------------------------------------------------------------------------
// Byte ring FIFO core
// Byte FIFO over a power-of-two ring with bulk put, bulk get and clear.
// ---------------------------------------------------------------------------
// A put word is taken every cycle while busy is low; its final word yields one
// status result in the next cycle. A get that moves bytes holds busy after it
// is taken while it reads them one after another on the single read port of the
// byte store; its bytes appear on consecutive cycles, each passing through the
// get state and the registered read data of the store; a get that moves
// nothing, and a clear, yield one status result in the next cycle. Results are
// shown for exactly one cycle under rsp_strobe and cannot be held off. Capacity
// writes are taken while busy and start are both low and clear both pointers.
// ---------------------------------------------------------------------------
module byte_ring_fifo_bulk_core (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         start,
   output logic                         busy,
   input  logic [brf_pkg::OP_W-1:0]     req_opcode,
   input  logic [brf_pkg::LEN_W-1:0]    req_request_length,
   input  logic [brf_pkg::BYTE_W-1:0]   req_put_byte,
   input  logic                         req_final_element,

   output logic                         rsp_strobe,
   output logic [brf_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_byte_valid,
   output logic [brf_pkg::LEN_W-1:0]    rsp_moved_count,
   output logic                         rsp_success,
   output logic [brf_pkg::FILL_W-1:0]   rsp_fill_level,
   output logic                         rsp_is_empty,
   output logic                         rsp_last_result,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [brf_pkg::LG_W-1:0]     csr_data
);

   localparam int ADDR_W = brf_pkg::ADDR_W;
   localparam int PTR_W  = brf_pkg::PTR_W;
   localparam int LEN_W  = brf_pkg::LEN_W;
   localparam int CMP_W  = brf_pkg::CMP_W;
   localparam int FILL_W = brf_pkg::FILL_W;

   typedef enum logic {
      ST_IDLE,
      ST_GET
   } state_type;

   state_type                  state_ff, state_in;
   logic [brf_pkg::LG_W-1:0]   cap_lg_ff, cap_lg_in;
   logic [PTR_W-1:0]           wp_ff, wp_in;
   logic [PTR_W-1:0]           rp_ff, rp_in;
   logic [LEN_W-1:0]           put_acc_ff, put_acc_in;
   logic [LEN_W-1:0]           put_off_ff, put_off_in;
   logic [ADDR_W-1:0]          get_addr_ff, get_addr_in;
   logic [LEN_W-1:0]           get_left_ff, get_left_in;
   logic [LEN_W-1:0]           get_n_ff, get_n_in;
   logic                       get_ok_ff, get_ok_in;
   logic [PTR_W-1:0]           get_fill_ff, get_fill_in;

   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]           rsp_moved_ff, rsp_moved_in;
   logic                       rsp_success_ff, rsp_success_in;
   logic [PTR_W-1:0]           rsp_fill_ff, rsp_fill_in;
   logic                       rsp_empty_ff, rsp_empty_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [PTR_W-1:0]           cap;
   logic [PTR_W:0]             pmask_wide;
   logic [PTR_W-1:0]           pmask;
   logic [ADDR_W-1:0]          amask;
   logic [PTR_W-1:0]           fill;
   logic [PTR_W-1:0]           space;
   logic [CMP_W-1:0]           len_c, fill_c, space_c, capped_c;
   logic [LEN_W-1:0]           capped;
   logic                       len_over;
   logic                       accept;
   logic                       csr_write;

   logic [LEN_W-1:0]           acc_new, acc_eff;
   logic [CMP_W-1:0]           put_addr_sum, wp_put_sum;
   logic [PTR_W-1:0]           wp_put, fill_put;
   logic                       put_ok;

   logic [LEN_W-1:0]           get_n;
   logic                       get_ok;
   logic [CMP_W-1:0]           rp_get_sum;
   logic [PTR_W-1:0]           rp_get, fill_get;
   logic                       get_last;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic                       rd_en;
   logic [brf_pkg::BYTE_W-1:0] rd_data;

   assign busy      = (state_ff == ST_GET);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign csr_write = csr_valid && csr_ready;
   assign accept    = start && !busy;

   assign cap        = PTR_W'(1) << cap_lg_ff;
   assign pmask_wide = {cap, 1'b0} - (PTR_W+1)'(1);
   assign pmask      = pmask_wide[PTR_W-1:0];
   assign amask      = ADDR_W'(cap - PTR_W'(1));
   assign fill       = (wp_ff - rp_ff) & pmask;
   assign space      = cap - fill;

   assign len_c    = CMP_W'(req_request_length);
   assign fill_c   = CMP_W'(fill);
   assign space_c  = CMP_W'(space);
   assign len_over = req_request_length > LEN_W'(brf_pkg::MAX_REQUEST);
   assign capped   = len_over ? LEN_W'(brf_pkg::MAX_REQUEST) : req_request_length;
   assign capped_c = CMP_W'(capped);

   always_comb begin
      if (req_opcode == brf_pkg::OP_PUT_PARTIAL) begin
         acc_new = (capped_c < space_c) ? capped : LEN_W'(space_c);
      end else begin
         acc_new = (len_over || (len_c > space_c)) ? '0 : req_request_length;
      end
   end

   assign acc_eff      = (put_off_ff == '0) ? acc_new : put_acc_ff;
   assign put_addr_sum = CMP_W'(wp_ff) + CMP_W'(put_off_ff);
   assign wr_addr      = ADDR_W'(put_addr_sum) & amask;
   assign wp_put_sum   = CMP_W'(wp_ff) + CMP_W'(acc_eff);
   assign wp_put       = PTR_W'(wp_put_sum) & pmask;
   assign fill_put     = (wp_put - rp_ff) & pmask;
   assign put_ok       = (req_opcode == brf_pkg::OP_PUT_PARTIAL) ||
                         (acc_eff == req_request_length);

   always_comb begin
      if (req_opcode == brf_pkg::OP_GET_PARTIAL) begin
         get_ok = 1'b1;
         get_n  = (capped_c < fill_c) ? capped : LEN_W'(fill_c);
      end else begin
         get_ok = !(len_over || (len_c > fill_c));
         get_n  = get_ok ? req_request_length : '0;
      end
   end

   assign rp_get_sum = CMP_W'(rp_ff) + CMP_W'(get_n);
   assign rp_get     = PTR_W'(rp_get_sum) & pmask;
   assign fill_get   = (wp_ff - rp_get) & pmask;
   assign get_last   = (get_left_ff == LEN_W'(1));

   assign wr_en = accept && (req_opcode == brf_pkg::OP_PUT_PARTIAL ||
                             req_opcode == brf_pkg::OP_PUT_FIXED) &&
                  (put_off_ff < acc_eff);
   assign rd_en = (state_ff == ST_GET);

   always_comb begin
      state_in       = state_ff;
      cap_lg_in      = cap_lg_ff;
      wp_in          = wp_ff;
      rp_in          = rp_ff;
      put_acc_in     = put_acc_ff;
      put_off_in     = put_off_ff;
      get_addr_in    = get_addr_ff;
      get_left_in    = get_left_ff;
      get_n_in       = get_n_ff;
      get_ok_in      = get_ok_ff;
      get_fill_in    = get_fill_ff;
      rsp_strobe_in  = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_moved_in   = '0;
      rsp_success_in = 1'b0;
      rsp_fill_in    = '0;
      rsp_empty_in   = 1'b0;
      rsp_last_in    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write) begin
               cap_lg_in  = brf_pkg::cap_lg_clamp(csr_data);
               wp_in      = '0;
               rp_in      = '0;
               put_acc_in = '0;
               put_off_in = '0;
            end else if (accept) begin
               case (req_opcode)
                  brf_pkg::OP_PUT_PARTIAL, brf_pkg::OP_PUT_FIXED: begin
                     put_acc_in = acc_eff;
                     put_off_in = (put_off_ff == '1) ? put_off_ff : put_off_ff + LEN_W'(1);
                     if (req_final_element) begin
                        wp_in          = wp_put;
                        put_acc_in     = '0;
                        put_off_in     = '0;
                        rsp_strobe_in  = 1'b1;
                        rsp_moved_in   = acc_eff;
                        rsp_success_in = put_ok;
                        rsp_fill_in    = fill_put;
                        rsp_empty_in   = (fill_put == '0);
                        rsp_last_in    = 1'b1;
                     end
                  end
                  brf_pkg::OP_GET_PARTIAL, brf_pkg::OP_GET_FIXED: begin
                     put_acc_in = '0;
                     put_off_in = '0;
                     if (get_n == '0) begin
                        rsp_strobe_in  = 1'b1;
                        rsp_success_in = get_ok;
                        rsp_fill_in    = fill;
                        rsp_empty_in   = (fill == '0);
                        rsp_last_in    = 1'b1;
                     end else begin
                        rp_in       = rp_get;
                        get_addr_in = ADDR_W'(rp_ff) & amask;
                        get_left_in = get_n;
                        get_n_in    = get_n;
                        get_ok_in   = get_ok;
                        get_fill_in = fill_get;
                        state_in    = ST_GET;
                     end
                  end
                  brf_pkg::OP_CLEAR: begin
                     put_acc_in     = '0;
                     put_off_in     = '0;
                     wp_in          = '0;
                     rp_in          = '0;
                     rsp_strobe_in  = 1'b1;
                     rsp_success_in = 1'b1;
                     rsp_empty_in   = 1'b1;
                     rsp_last_in    = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GET: begin
            get_addr_in   = (get_addr_ff + ADDR_W'(1)) & amask;
            get_left_in   = get_left_ff - LEN_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_valid_in  = 1'b1;
            if (get_last) begin
               rsp_moved_in   = get_n_ff;
               rsp_success_in = get_ok_ff;
               rsp_fill_in    = get_fill_ff;
               rsp_empty_in   = (get_fill_ff == '0);
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_lg_ff     <= brf_pkg::cap_lg_clamp(brf_pkg::LG_W'(brf_pkg::LG_RESET));
         wp_ff         <= '0;
         rp_ff         <= '0;
         put_acc_ff    <= '0;
         put_off_ff    <= '0;
         get_left_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_lg_ff     <= cap_lg_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         put_acc_ff    <= put_acc_in;
         put_off_ff    <= put_off_in;
         get_left_ff   <= get_left_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      get_addr_ff    <= get_addr_in;
      get_n_ff       <= get_n_in;
      get_ok_ff      <= get_ok_in;
      get_fill_ff    <= get_fill_in;
      rsp_valid_ff   <= rsp_valid_in;
      rsp_moved_ff   <= rsp_moved_in;
      rsp_success_ff <= rsp_success_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_last_ff    <= rsp_last_in;
   end

   brf_ram #(
      .WIDTH (brf_pkg::BYTE_W),
      .DEPTH (brf_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_put_byte),
      .rd_en   (rd_en),
      .rd_addr (get_addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_byte_valid  = rsp_valid_ff;
   assign rsp_out_byte    = rsp_valid_ff ? rd_data : '0;
   assign rsp_moved_count = rsp_moved_ff;
   assign rsp_success     = rsp_success_ff;
   assign rsp_fill_level  = FILL_W'(rsp_fill_ff);
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule
